FILE: rtl/core/sht_pkg.sv
// sht_pkg: shared constants, codes, types and the hash function of the
// scoped hash symbol table; used by sht_ctrl and the top module
`default_nettype none
package sht_pkg;

	localparam int unsigned BUCKET_COUNT_DEF = 4096;
	localparam int unsigned MAX_ENTRIES_DEF  = 1024;
	localparam int unsigned HIDDEN_DEPTH_DEF = 1024;

	localparam int unsigned HASH_SHIFT = 17;

	// operation codes
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_POP    = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TBL_FULL  = 2'd1;
	localparam logic [1:0] ST_HID_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD_MARKS = 2'd3;

	// bucket tags
	localparam logic [1:0] TAG_LIVE  = 2'd0;
	localparam logic [1:0] TAG_EMPTY = 2'd1;
	localparam logic [1:0] TAG_DEL   = 2'd2;

	// probe outcomes
	localparam logic [1:0] PR_MISS   = 2'd0;
	localparam logic [1:0] PR_HIT    = 2'd1;
	localparam logic [1:0] PR_NOSLOT = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] key;
		logic [31:0] value;
		logic [10:0] entry_mark;
		logic [10:0] hidden_mark;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] found_value;
		logic        pending_flag;
		logic [10:0] entry_count;
		logic [10:0] hidden_count;
		logic [1:0]  status;
	} res_t;

	function automatic logic [31:0] hash_key(input logic [31:0] k);
		return k ^ (k >> HASH_SHIFT);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sht_ram.sv
// sht_ram: simple dual-port synchronous memory, one write and one read port,
// registered read data; no dependencies
`default_nettype none
module sht_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/sht_ctrl.sv
// sht_ctrl: sequencer of the symbol table with its bucket, key, binding and
// hidden stack memories; depends on sht_pkg and sht_ram
`default_nettype none
module sht_ctrl #(
	parameter int unsigned BUCKET_COUNT = sht_pkg::BUCKET_COUNT_DEF,
	parameter int unsigned MAX_ENTRIES  = sht_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned HIDDEN_DEPTH = sht_pkg::HIDDEN_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sht_pkg::req_t req,
	input  wire logic [15:0]   level,
	output logic               res_valid,
	input  wire logic          res_ready,
	output sht_pkg::res_t      res
);

	localparam int unsigned BW   = $clog2(BUCKET_COUNT);
	localparam int unsigned IW   = $clog2(MAX_ENTRIES);
	localparam int unsigned EW   = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned HIW  = $clog2(HIDDEN_DEPTH);
	localparam int unsigned HUW  = $clog2(HIDDEN_DEPTH + 1);
	localparam int unsigned TCW  = $clog2(BUCKET_COUNT + 1);
	localparam int unsigned SW   = IW + 2;
	localparam int unsigned BDW  = 48;
	localparam int unsigned HW   = BDW + IW;
	localparam logic [TCW-1:0] TC_LIMIT = TCW'(BUCKET_COUNT >> 3);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_P_RD, S_P_BK, S_P_KEY, S_P_END,
		S_ADD_SH, S_LOOK_RD, S_POP_H, S_POP_HW, S_POP_E, S_POP_EK,
		S_PD_NRD, S_PD_NBK, S_PD_EW, S_PD_ERD, S_PD_EBK,
		S_RB_NEXT, S_RB_K, S_FIN, S_DONE
	} state_t;

	typedef enum logic [1:0] {CTX_ADD, CTX_LOOK, CTX_POP, CTX_BUILD} ctx_t;

	state_t state_q;
	ctx_t   ctx_q;

	logic [31:0]  val_q;
	logic [10:0]  emark_q, hmark_q;
	logic [EW-1:0]  eu_q, e_q, rb_q;
	logic [HUW-1:0] hu_q;
	logic [TCW-1:0] tc_q;
	logic [BW-1:0]  clr_q, idx_q, del_q, pos_q, n_q;
	logic [31:0]  pkey_q;
	logic         hd_q, pos_del_q;
	logic [IW-1:0] pslot_q;
	logic [1:0]   pr_q;

	// memory ports
	logic          b_we;
	logic [BW-1:0] b_waddr, b_raddr;
	logic [SW-1:0] b_wdata, b_rdata;
	logic          k_we;
	logic [IW-1:0] k_waddr, k_raddr;
	logic [31:0]   k_rdata;
	logic          bd_we;
	logic [IW-1:0] bd_waddr, bd_raddr;
	logic [BDW-1:0] bd_wdata, bd_rdata;
	logic          h_we;
	logic [HIW-1:0] h_waddr, h_raddr;
	logic [HW-1:0] h_wdata, h_rdata;

	logic [EW-1:0]  eu_dec;
	logic [HUW-1:0] hu_dec;
	logic           add_ok, pop_hit;
	logic [TCW-1:0] tc_add;

	assign eu_dec  = eu_q - 1'b1;
	assign hu_dec  = hu_q - 1'b1;
	assign add_ok  = (pr_q != sht_pkg::PR_NOSLOT) && (eu_q < EW'(MAX_ENTRIES));
	assign pop_hit = (pr_q == sht_pkg::PR_HIT) && (pslot_q == e_q[IW-1:0]);
	assign tc_add  = (pos_del_q && tc_q != '0) ? tc_q - 1'b1 : tc_q;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	sht_ram #(.WIDTH(SW), .DEPTH(BUCKET_COUNT)) u_bucket (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	sht_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(pkey_q),
		.raddr(k_raddr), .rdata(k_rdata)
	);
	sht_ram #(.WIDTH(BDW), .DEPTH(MAX_ENTRIES)) u_bind (
		.clk(clk), .we(bd_we), .waddr(bd_waddr), .wdata(bd_wdata),
		.raddr(bd_raddr), .rdata(bd_rdata)
	);
	sht_ram #(.WIDTH(HW), .DEPTH(HIDDEN_DEPTH)) u_hidden (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	always_comb begin
		b_we     = 1'b0;
		b_waddr  = idx_q;
		b_wdata  = {sht_pkg::TAG_EMPTY, {IW{1'b0}}};
		b_raddr  = idx_q;
		k_we     = 1'b0;
		k_waddr  = eu_q[IW-1:0];
		k_raddr  = pslot_q;
		bd_we    = 1'b0;
		bd_waddr = pslot_q;
		bd_wdata = {level, val_q};
		bd_raddr = pslot_q;
		h_we     = 1'b0;
		h_waddr  = hu_q[HIW-1:0];
		h_wdata  = {pslot_q, bd_rdata};
		h_raddr  = hu_dec[HIW-1:0];
		case (state_q)
			S_CLEAR: begin
				b_we    = 1'b1;
				b_waddr = clr_q;
			end
			S_P_BK: begin
				k_raddr = b_rdata[IW-1:0];
			end
			S_P_END: begin
				case (ctx_q)
					CTX_ADD: begin
						if (pr_q != sht_pkg::PR_HIT && add_ok) begin
							b_we     = 1'b1;
							b_waddr  = pos_q;
							b_wdata  = {sht_pkg::TAG_LIVE, eu_q[IW-1:0]};
							k_we     = 1'b1;
							bd_we    = 1'b1;
							bd_waddr = eu_q[IW-1:0];
						end
					end
					CTX_POP: begin
						if (pop_hit) begin
							b_we    = 1'b1;
							b_waddr = pos_q;
							b_wdata = {sht_pkg::TAG_DEL, {IW{1'b0}}};
						end
					end
					CTX_BUILD: begin
						if (pr_q == sht_pkg::PR_MISS) begin
							b_we    = 1'b1;
							b_waddr = pos_q;
							b_wdata = {sht_pkg::TAG_LIVE, rb_q[IW-1:0]};
						end
					end
					default: ;
				endcase
			end
			S_ADD_SH: begin
				h_we  = 1'b1;
				bd_we = 1'b1;
			end
			S_POP_HW: begin
				bd_we    = 1'b1;
				bd_waddr = h_rdata[HW-1:BDW];
				bd_wdata = h_rdata[BDW-1:0];
			end
			S_POP_E:   k_raddr = eu_dec[IW-1:0];
			S_PD_NRD:  b_raddr = pos_q + 1'b1;
			S_PD_EW:   b_we = 1'b1;
			S_RB_NEXT: k_raddr = rb_q[IW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ctx_q     <= CTX_ADD;
			clr_q     <= '0;
			eu_q      <= '0;
			hu_q      <= '0;
			tc_q      <= '0;
			rb_q      <= '0;
			e_q       <= '0;
			n_q       <= '0;
			hd_q      <= 1'b0;
			pos_del_q <= 1'b0;
			pr_q      <= sht_pkg::PR_MISS;
			res       <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKET_COUNT - 1)) begin
						if (ctx_q == CTX_BUILD) begin
							rb_q    <= '0;
							state_q <= S_RB_NEXT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						val_q   <= req.value;
						emark_q <= req.entry_mark;
						hmark_q <= req.hidden_mark;
						res.found        <= 1'b0;
						res.found_value  <= '0;
						res.pending_flag <= 1'b0;
						res.status       <= sht_pkg::ST_OK;
						pkey_q <= req.key;
						idx_q  <= BW'(sht_pkg::hash_key(req.key));
						n_q    <= '0;
						hd_q   <= 1'b0;
						case (req.func)
							sht_pkg::FUNC_ADD: begin
								ctx_q   <= CTX_ADD;
								state_q <= S_P_RD;
							end
							sht_pkg::FUNC_LOOKUP: begin
								ctx_q   <= CTX_LOOK;
								state_q <= S_P_RD;
							end
							sht_pkg::FUNC_POP: begin
								ctx_q <= CTX_POP;
								if (32'(req.entry_mark) > 32'(eu_q) ||
									32'(req.hidden_mark) > 32'(hu_q)) begin
									res.status <= sht_pkg::ST_BAD_MARKS;
									state_q    <= S_DONE;
								end else begin
									state_q <= S_POP_H;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_P_RD: state_q <= S_P_BK;
				S_P_BK: begin
					if (b_rdata[SW-1:IW] == sht_pkg::TAG_EMPTY) begin
						pr_q      <= sht_pkg::PR_MISS;
						pos_q     <= hd_q ? del_q : idx_q;
						pos_del_q <= hd_q;
						state_q   <= S_P_END;
					end else if (b_rdata[SW-1:IW] == sht_pkg::TAG_DEL) begin
						if (!hd_q) begin
							hd_q  <= 1'b1;
							del_q <= idx_q;
						end
						if (n_q == BW'(BUCKET_COUNT - 1)) begin
							pr_q      <= sht_pkg::PR_MISS;
							pos_q     <= hd_q ? del_q : idx_q;
							pos_del_q <= 1'b1;
							state_q   <= S_P_END;
						end else begin
							n_q     <= n_q + 1'b1;
							idx_q   <= idx_q + 1'b1;
							state_q <= S_P_RD;
						end
					end else begin
						pslot_q <= b_rdata[IW-1:0];
						state_q <= S_P_KEY;
					end
				end
				S_P_KEY: begin
					if (k_rdata == pkey_q) begin
						pr_q    <= sht_pkg::PR_HIT;
						pos_q   <= idx_q;
						state_q <= S_P_END;
					end else if (n_q == BW'(BUCKET_COUNT - 1)) begin
						pr_q      <= hd_q ? sht_pkg::PR_MISS : sht_pkg::PR_NOSLOT;
						pos_q     <= del_q;
						pos_del_q <= 1'b1;
						state_q   <= S_P_END;
					end else begin
						n_q     <= n_q + 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_P_RD;
					end
				end
				S_P_END: begin
					case (ctx_q)
						CTX_ADD: begin
							if (pr_q == sht_pkg::PR_HIT) begin
								res.found <= 1'b1;
								if (hu_q >= HUW'(HIDDEN_DEPTH)) begin
									res.status <= sht_pkg::ST_HID_FULL;
									state_q    <= S_DONE;
								end else begin
									state_q <= S_ADD_SH;
								end
							end else if (!add_ok) begin
								res.status <= sht_pkg::ST_TBL_FULL;
								state_q    <= S_DONE;
							end else begin
								eu_q <= eu_q + 1'b1;
								if (tc_add > TC_LIMIT) begin
									tc_q    <= '0;
									ctx_q   <= CTX_BUILD;
									clr_q   <= '0;
									state_q <= S_CLEAR;
								end else begin
									tc_q    <= tc_add;
									state_q <= S_FIN;
								end
							end
						end
						CTX_LOOK: begin
							if (pr_q == sht_pkg::PR_HIT) begin
								state_q <= S_LOOK_RD;
							end else begin
								res.pending_flag <= (level != 16'd0);
								state_q          <= S_DONE;
							end
						end
						CTX_POP: begin
							if (pop_hit) begin
								tc_q    <= tc_q + 1'b1;
								state_q <= S_PD_NRD;
							end else begin
								state_q <= S_POP_E;
							end
						end
						default: begin
							rb_q    <= rb_q + 1'b1;
							state_q <= S_RB_NEXT;
						end
					endcase
				end
				S_ADD_SH: begin
					hu_q    <= hu_q + 1'b1;
					state_q <= S_FIN;
				end
				S_LOOK_RD: begin
					res.found        <= 1'b1;
					res.found_value  <= bd_rdata[31:0];
					res.pending_flag <= (level != bd_rdata[BDW-1:32]);
					state_q          <= S_DONE;
				end
				S_POP_H: begin
					if (32'(hu_q) > 32'(hmark_q)) begin
						hu_q    <= hu_dec;
						state_q <= S_POP_HW;
					end else begin
						state_q <= S_POP_E;
					end
				end
				S_POP_HW: state_q <= S_POP_H;
				S_POP_E: begin
					if (32'(eu_q) > 32'(emark_q)) begin
						eu_q    <= eu_dec;
						e_q     <= eu_dec;
						state_q <= S_POP_EK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_POP_EK: begin
					pkey_q  <= k_rdata;
					idx_q   <= BW'(sht_pkg::hash_key(k_rdata));
					n_q     <= '0;
					hd_q    <= 1'b0;
					state_q <= S_P_RD;
				end
				S_PD_NRD: state_q <= S_PD_NBK;
				S_PD_NBK: begin
					if (b_rdata[SW-1:IW] == sht_pkg::TAG_EMPTY) begin
						idx_q   <= pos_q;
						state_q <= S_PD_EW;
					end else begin
						state_q <= S_POP_E;
					end
				end
				S_PD_EW: begin
					if (tc_q != '0) begin
						tc_q <= tc_q - 1'b1;
					end
					idx_q   <= idx_q - 1'b1;
					state_q <= S_PD_ERD;
				end
				S_PD_ERD: state_q <= S_PD_EBK;
				S_PD_EBK: begin
					if (b_rdata[SW-1:IW] == sht_pkg::TAG_DEL) begin
						state_q <= S_PD_EW;
					end else begin
						state_q <= S_POP_E;
					end
				end
				S_RB_NEXT: begin
					if (rb_q < eu_q) begin
						state_q <= S_RB_K;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RB_K: begin
					pkey_q  <= k_rdata;
					idx_q   <= BW'(sht_pkg::hash_key(k_rdata));
					n_q     <= '0;
					hd_q    <= 1'b0;
					state_q <= S_P_RD;
				end
				// counts settle into the result before it is offered
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			res.entry_count  <= 11'(eu_q);
			res.hidden_count <= 11'(hu_q);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/scoped_hash_symbol_table.sv
// scoped hash symbol table: a transaction probes buckets from the key's hash, reading
// the key of each live bucket; a lookup hit then reads the binding, an add appends an entry
// or, on a hit, shadows the old binding; pops restore hidden bindings, delete entries by a
// probe and turn runs of deleted buckets back to empty; a rebuild sweeps the buckets and
// probes every entry again. one transaction in flight at a time.
// after reset the buckets are swept to empty, s_axis_tready low
`default_nettype none
module scoped_hash_symbol_table #(
	parameter int unsigned BUCKET_COUNT = sht_pkg::BUCKET_COUNT_DEF,
	parameter int unsigned MAX_ENTRIES  = sht_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned HIDDEN_DEPTH = sht_pkg::HIDDEN_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pending level register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [87:0] s_axis_tdata,  // key[31:0], value[63:32], entry_mark[74:64],
	                                        // hidden_mark[85:75], zero pad
	input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata   // found[0], found_value[32:1], pending_flag[33],
	                                        // entry_count[44:34], hidden_count[55:45],
	                                        // status[57:56], zero pad
);

	logic [15:0]   level_q;
	sht_pkg::req_t req;
	sht_pkg::res_t res;
	logic          res_valid, res_ready;

	// config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_valid) begin
			level_q <= cfg_data;
		end
	end

	// unpack request fields
	assign req.func        = s_axis_tuser;
	assign req.key         = s_axis_tdata[31:0];
	assign req.value       = s_axis_tdata[63:32];
	assign req.entry_mark  = s_axis_tdata[74:64];
	assign req.hidden_mark = s_axis_tdata[85:75];

	sht_ctrl #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.MAX_ENTRIES (MAX_ENTRIES),
		.HIDDEN_DEPTH(HIDDEN_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req      (req),
		.level    (level_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register: frees the sequencer as soon as the result is captured
	assign res_ready = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_axis_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_axis_tdata <= {6'd0, res.status, res.hidden_count, res.entry_count,
				res.pending_flag, res.found_value, res.found};
		end
	end

endmodule
`default_nettype wire
